// ===== design/mscc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the magnetometer sample corrector.
// No dependencies; imported by the top level, mscc_gain, mscc_cal and mscc_tilt.
package mscc_pkg;

  localparam int unsigned READ_INTERVAL_US_DEF = 100000;
  localparam int unsigned CAL_WINDOW_US_DEF    = 30000000;

  localparam int unsigned CFG_AW     = 5;
  localparam logic [15:0] GAIN_RESET = 16'd4096;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_GAIN_X      = 3'd0;
  localparam logic [2:0] REG_GAIN_Y      = 3'd1;
  localparam logic [2:0] REG_GAIN_Z      = 3'd2;
  localparam logic [2:0] REG_TILT_MODE   = 3'd3;
  localparam logic [2:0] REG_ZERO_INIT_X = 3'd4;
  localparam logic [2:0] REG_ZERO_INIT_Y = 3'd5;
  localparam logic [2:0] REG_ZERO_INIT_Z = 3'd6;

  localparam logic [1:0] TILT_NONE  = 2'd0;
  localparam logic [1:0] TILT_LEFT  = 2'd1;
  localparam logic [1:0] TILT_RIGHT = 2'd2;

  typedef logic signed [15:0] s16_t;

  typedef struct packed {
    logic              action;
    logic [31:0]       time_us;
    s16_t [2:0]        val;
  } gain_item_t;

  typedef struct packed {
    s16_t [2:0]        mag;
    logic              calibrating;
    logic              done;
    logic              changed;
    s16_t [2:0]        zero;
  } cal_item_t;

  typedef struct packed {
    logic [2:0]        load;
    s16_t              value;
  } zload_t;

  function automatic s16_t sat16(input logic signed [20:0] v);
    s16_t r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/mag_sample_correct_calibrate.sv =====
`timescale 1ns / 1ps
// Top level of the magnetometer sample corrector with min/max calibration.
// Depends on mscc_pkg, mscc_gain, mscc_cal and mscc_tilt.
//
// Usage:
//   in_*  : one transaction per sample or calibrate request (in_tuser = 1).
//   out_* : one transaction per sample accepted past the read deadline;
//           requests and early samples give none.
//   cfg_* : APB register port, registers at byte address 4*index, always ready.
//           Write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_tready is high. A result
// passes through four register stages in order (input, gain multiply,
// deadline/calibration state, tilt rotation), and the deadline and
// calibration state are updated as each item passes.
// Reset (rst_n low, synchronous): pipeline emptied, gains 1.0, tilt off,
// deadline, calibration state and working zeros cleared.
// A stall on out_tready holds the result register; upstream stages keep
// accepting until each stage is full, then in_tready drops.
module mag_sample_correct_calibrate import mscc_pkg::*; #(
  parameter int unsigned READ_INTERVAL_US = READ_INTERVAL_US_DEF,
  parameter int unsigned CAL_WINDOW_US    = CAL_WINDOW_US_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,   // time_us, raw_x, raw_y, raw_z
  input  logic [0:0]        in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // mag_x, mag_y, mag_z, zero_x, zero_y, zero_z
  output logic [2:0]        out_tuser,  // calibrating, cal_done, extreme_changed
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [2:0][15:0] gain_r;
  logic [1:0]       tilt_r;
  s16_t [2:0]       zinit_r;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  zload_t           zload;
  s16_t [2:0]       raw;

  logic             g_valid;
  logic             g_ready;
  gain_item_t       g_item;
  logic             c_valid;
  logic             c_ready;
  cal_item_t        c_item;
  cal_item_t        t_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= {3{GAIN_RESET}};
      tilt_r  <= TILT_NONE;
      zinit_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_X:      gain_r[0]  <= cfg_pwdata[15:0];
        REG_GAIN_Y:      gain_r[1]  <= cfg_pwdata[15:0];
        REG_GAIN_Z:      gain_r[2]  <= cfg_pwdata[15:0];
        REG_TILT_MODE:   tilt_r     <= cfg_pwdata[1:0];
        REG_ZERO_INIT_X: zinit_r[0] <= cfg_pwdata[15:0];
        REG_ZERO_INIT_Y: zinit_r[1] <= cfg_pwdata[15:0];
        REG_ZERO_INIT_Z: zinit_r[2] <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_X:      cfg_prdata = {16'd0, gain_r[0]};
      REG_GAIN_Y:      cfg_prdata = {16'd0, gain_r[1]};
      REG_GAIN_Z:      cfg_prdata = {16'd0, gain_r[2]};
      REG_TILT_MODE:   cfg_prdata = {30'd0, tilt_r};
      REG_ZERO_INIT_X: cfg_prdata = {16'd0, zinit_r[0]};
      REG_ZERO_INIT_Y: cfg_prdata = {16'd0, zinit_r[1]};
      REG_ZERO_INIT_Z: cfg_prdata = {16'd0, zinit_r[2]};
      default:         cfg_prdata = '0;
    endcase
  end

  assign zload.load[0] = cfg_wr && (cfg_idx == REG_ZERO_INIT_X);
  assign zload.load[1] = cfg_wr && (cfg_idx == REG_ZERO_INIT_Y);
  assign zload.load[2] = cfg_wr && (cfg_idx == REG_ZERO_INIT_Z);
  assign zload.value   = cfg_pwdata[15:0];

  assign raw[0] = in_tdata[47:32];
  assign raw[1] = in_tdata[63:48];
  assign raw[2] = in_tdata[79:64];

  mscc_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser[0]),
    .in_time   (in_tdata[31:0]),
    .in_raw    (raw),
    .gain      (gain_r),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_item  (g_item)
  );

  mscc_cal #(
    .READ_INTERVAL_US (READ_INTERVAL_US),
    .CAL_WINDOW_US    (CAL_WINDOW_US)
  ) u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_item   (g_item),
    .zload     (zload),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_item  (c_item)
  );

  mscc_tilt u_tilt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_item   (c_item),
    .tilt_mode (tilt_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (t_item)
  );

  assign out_tdata = {t_item.zero[2], t_item.zero[1], t_item.zero[0],
                      t_item.mag[2], t_item.mag[1], t_item.mag[0]};
  assign out_tuser = {t_item.changed, t_item.done, t_item.calibrating};

endmodule

// ===== design/mscc_gain.sv =====
`timescale 1ns / 1ps
// Input register and per-axis Q4.12 gain stage (truncate toward zero, saturate).
// Depends on mscc_pkg.
module mscc_gain import mscc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [31:0]      in_time,
  input  s16_t [2:0]       in_raw,
  input  logic [2:0][15:0] gain,
  output logic             out_valid,
  input  logic             out_ready,
  output gain_item_t       out_item
);

  logic        s1_valid_r;
  logic        s1_action_r;
  logic [31:0] s1_time_r;
  s16_t [2:0]  s1_raw_r;
  logic        s2_valid_r;
  gain_item_t  s2_item_r;
  gain_item_t  s2_item_nxt;
  logic        s1_ready;
  logic        s2_ready;

  logic signed [32:0] prod [3];
  logic signed [32:0] padj [3];

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    s2_item_nxt.action  = s1_action_r;
    s2_item_nxt.time_us = s1_time_r;
    for (int i = 0; i < 3; i++) begin
      prod[i] = $signed(s1_raw_r[i]) * $signed({1'b0, gain[i]});
      // round toward zero before the shift
      padj[i] = prod[i] + (prod[i][32] ? 33'sd4095 : 33'sd0);
      s2_item_nxt.val[i] = sat16($signed(padj[i][32:12]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_action_r <= in_action;
      s1_time_r   <= in_time;
      s1_raw_r    <= in_raw;
    end
    if (s1_valid_r && s2_ready) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_item  = s2_item_r;

endmodule

// ===== design/mscc_cal.sv =====
`timescale 1ns / 1ps
// Read deadline, offset subtraction and min/max calibration window state.
// Depends on mscc_pkg.
module mscc_cal import mscc_pkg::*; #(
  parameter int unsigned READ_INTERVAL_US = READ_INTERVAL_US_DEF,
  parameter int unsigned CAL_WINDOW_US    = CAL_WINDOW_US_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  gain_item_t in_item,
  input  zload_t     zload,
  output logic       out_valid,
  input  logic       out_ready,
  output cal_item_t  out_item
);

  localparam logic [31:0] INTERVAL = READ_INTERVAL_US[31:0];
  localparam logic [31:0] WINDOW   = CAL_WINDOW_US[31:0];

  logic [31:0] deadline_r;
  logic        cal_request_r;
  logic        cal_started_r;
  logic [31:0] cal_start_r;
  s16_t        min_r  [3];
  s16_t        max_r  [3];
  s16_t        zero_r [3];
  logic        out_valid_r;
  cal_item_t   out_item_r;

  logic        fire;
  logic        early;
  logic        sample;
  logic        first;
  logic        in_win;
  logic        win_upd;
  logic [31:0] nd;
  logic [31:0] start;
  logic        chg_any;
  s16_t        g      [3];
  s16_t        v      [3];
  s16_t        mn_nxt [3];
  s16_t        mx_nxt [3];
  s16_t        z_nxt  [3];
  logic signed [20:0] diff [3];
  logic signed [16:0] zsum [3];
  cal_item_t   out_item_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    nd      = in_item.time_us + INTERVAL;
    early   = in_item.time_us < deadline_r;
    sample  = fire && !in_item.action && !early;
    first   = !cal_started_r;
    start   = first ? nd : cal_start_r;
    in_win  = (nd - start) < WINDOW;
    win_upd = cal_request_r && in_win;
    chg_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      g[i]    = in_item.val[i];
      diff[i] = $signed({{5{g[i][15]}}, g[i]}) - $signed({{5{zero_r[i][15]}}, zero_r[i]});
      v[i]    = cal_request_r ? g[i] : sat16(diff[i]);
      mn_nxt[i] = (first || v[i] < min_r[i]) ? v[i] : min_r[i];
      mx_nxt[i] = (first || v[i] > max_r[i]) ? v[i] : max_r[i];
      if (!first && (v[i] < min_r[i] || v[i] > max_r[i])) begin
        chg_any = 1'b1;
      end
      zsum[i] = $signed({mn_nxt[i][15], mn_nxt[i]}) + $signed({mx_nxt[i][15], mx_nxt[i]});
      z_nxt[i] = win_upd ? zsum[i][16:1] : zero_r[i];
      out_item_nxt.mag[i]  = v[i];
      out_item_nxt.zero[i] = z_nxt[i];
    end
    out_item_nxt.calibrating = win_upd;
    out_item_nxt.done        = cal_request_r && !in_win;
    out_item_nxt.changed     = win_upd && chg_any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r      <= '0;
      cal_request_r   <= 1'b0;
      cal_started_r   <= 1'b0;
      cal_start_r     <= '0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        zero_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        out_valid_r <= sample;
      end
      if (fire && in_item.action) begin
        cal_request_r <= 1'b1;
      end
      if (sample) begin
        deadline_r      <= nd;
        if (cal_request_r) begin
          if (in_win) begin
            cal_started_r <= 1'b1;
            cal_start_r   <= start;
          end else begin
            cal_request_r <= 1'b0;
            cal_started_r <= 1'b0;
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (zload.load[i]) begin
          zero_r[i] <= zload.value;
        end else if (sample) begin
          zero_r[i] <= z_nxt[i];
        end
      end
    end
  end

  // extremes carry no reset: always loaded on the first window sample
  always_ff @(posedge clk) begin
    if (sample && win_upd) begin
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= mn_nxt[i];
        max_r[i] <= mx_nxt[i];
      end
    end
    if (sample) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/mscc_tilt.sv =====
`timescale 1ns / 1ps
// Optional +/-45 degree tilt rotation, (a +/- b) * 7 / 10, and result register.
// Depends on mscc_pkg.
module mscc_tilt import mscc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cal_item_t  in_item,
  input  logic [1:0] tilt_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output cal_item_t  out_item
);

  // ceil(2^22 / 10) * 7; exact floor(7m/10) for m up to 2^16
  localparam logic [21:0] RECIP_7_10 = 22'd2936017;

  logic      out_valid_r;
  cal_item_t out_item_r;
  cal_item_t out_item_nxt;
  s16_t      r;
  s16_t      p;
  logic signed [16:0] r_plus_p;
  logic signed [16:0] r_minus_p;
  logic signed [16:0] p_minus_r;

  function automatic s16_t scale710(input logic signed [16:0] s);
    logic [16:0]        m;
    logic [38:0]        prod;
    logic [16:0]        q;
    logic signed [20:0] sq;
    m    = s[16] ? 17'(-s) : 17'(s);
    prod = m * RECIP_7_10;
    q    = prod[38:22];
    sq   = s[16] ? -$signed({4'b0, q}) : $signed({4'b0, q});
    return sat16(sq);
  endfunction

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    r         = in_item.mag[0];
    p         = in_item.mag[1];
    r_plus_p  = $signed({r[15], r}) + $signed({p[15], p});
    r_minus_p = $signed({r[15], r}) - $signed({p[15], p});
    p_minus_r = $signed({p[15], p}) - $signed({r[15], r});
    out_item_nxt = in_item;
    unique case (tilt_mode)
      TILT_LEFT: begin
        out_item_nxt.mag[0] = scale710(r_plus_p);
        out_item_nxt.mag[1] = scale710(p_minus_r);
      end
      TILT_RIGHT: begin
        out_item_nxt.mag[0] = scale710(r_minus_p);
        out_item_nxt.mag[1] = scale710(r_plus_p);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/mscc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the magnetometer sample corrector, bound to the top level.
// Depends only on the top level's ports.
module mscc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("calibrating and cal_done both set");

  a_chg_in_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0])
    else $error("extreme_changed outside calibration window");

endmodule

bind mag_sample_correct_calibrate mscc_checker u_mscc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
